// File: rtl/core/latency_percentile_stats_macros.svh
// Assertion macros shared by the latency statistics block.
// Depends on nothing; included by the top level only.
`ifndef LATENCY_PERCENTILE_STATS_MACROS_SVH
`define LATENCY_PERCENTILE_STATS_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define LPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define LPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/lps_pkg.sv
// Shared types and constants for the latency percentile statistics block.
// Depends on nothing.
`timescale 1ns / 1ps

package lps_pkg;

   localparam int MAX_SAMPLES = 65536;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int COUNT_W     = ADDR_W + 1;
   localparam int SAMPLE_W    = 32;
   localparam int BIT_IDX_W   = $clog2(SAMPLE_W);
   localparam int SUM_W       = 48;
   localparam int MEAN_W      = 40;
   localparam int FRAC_W      = 8;
   localparam int DIV_W       = SUM_W + FRAC_W;
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
   localparam int POINT_W     = 14;
   localparam int NUM_POINTS  = 5;
   localparam int PIDX_W      = $clog2(NUM_POINTS);
   localparam int CSR_IDX_W   = 3;
   localparam int FULL_SCALE  = 10000;
   localparam int PROD_W      = POINT_W + COUNT_W;
   // floor(x / 10000) == (x * RECIP) >> RECIP_SHIFT for every x below 2^30
   localparam int RECIP_W     = 30;
   localparam int RECIP_SHIFT = 43;
   localparam logic [RECIP_W-1:0] RECIP = 30'd879609303;
   localparam int WIDE_W      = PROD_W + RECIP_W;
   localparam int STEP_W      = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_E = 3'd4;

   typedef logic [NUM_POINTS-1:0][POINT_W-1:0]  point_vec_type;
   typedef logic [NUM_POINTS-1:0][COUNT_W-1:0]  rank_vec_type;
   typedef logic [NUM_POINTS-1:0][SAMPLE_W-1:0] value_vec_type;

   localparam point_vec_type POINT_RESET = {14'd9999, 14'd9990, 14'd9900, 14'd9000, 14'd5000};

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_value;
      logic                has_sample;
      logic                set_end;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  sample_count;
      logic [SAMPLE_W-1:0] min_value;
      logic [SAMPLE_W-1:0] max_value;
      logic [MEAN_W-1:0]   mean_q8;
      logic [SAMPLE_W-1:0] pct_a_value;
      logic [SAMPLE_W-1:0] pct_b_value;
      logic [SAMPLE_W-1:0] pct_c_value;
      logic [SAMPLE_W-1:0] pct_d_value;
      logic [SAMPLE_W-1:0] pct_e_value;
      logic                overflowed;
   } rsp_type;

   // Control from the sequencer to the selection lanes
   typedef struct packed {
      logic                 clear;
      logic                 rd_valid;
      logic                 pass_end;
      logic [BIT_IDX_W-1:0] bit_idx;
   } scan_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANK,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_WAIT_DIV,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/core/latency_percentile_stats.sv
// Latency percentile statistics: collects samples, then reports count, min, max,
// mean and five nearest-rank percentiles. Samples load at one per cycle while idle.
// A closing item makes one scan of the sample memory per result bit, through its
// single read port.
// An empty set answers in the cycle after the closing item. The strobe cannot stall.
// Reset (synchronous) clears the set and restores the default percentile points.
`timescale 1ns / 1ps
`include "latency_percentile_stats_macros.svh"

module latency_percentile_stats (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              start,
   output logic                              busy,
   input  lps_pkg::req_type                  req_data,
   // result channel
   output logic                              rsp_valid,
   output lps_pkg::rsp_type                  rsp_data,
   // configuration channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lps_pkg::POINT_W-1:0]       csr_wdata
);

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   lps_pkg::state_type             state_ff, state_in;
   lps_pkg::point_vec_type         points_ff, points_in;
   logic [lps_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [lps_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic                           drop_ff, drop_in;
   logic [lps_pkg::SAMPLE_W-1:0]   min_ff, min_in;
   logic [lps_pkg::SAMPLE_W-1:0]   max_ff, max_in;
   logic [lps_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [lps_pkg::PROD_W-1:0]     prod_ff, prod_in;
   lps_pkg::rank_vec_type          rank_ff, rank_in;
   logic [lps_pkg::COUNT_W-1:0]    addr_ff, addr_in;
   logic [lps_pkg::BIT_IDX_W-1:0]  bit_ff, bit_in;
   logic                           rd_valid_ff;

   logic                           accept;
   logic                           store_ok;
   logic                           wr_en;
   logic                           rd_en;
   logic                           div_start;
   logic                           div_done;
   logic [lps_pkg::MEAN_W-1:0]     mean;
   logic [lps_pkg::SAMPLE_W-1:0]   rd_data;
   lps_pkg::value_vec_type         pct;
   lps_pkg::scan_ctrl_type         scan_ctrl;
   logic [lps_pkg::PIDX_W-1:0]     pidx;
   logic [lps_pkg::POINT_W-1:0]    point_cl;
   logic [lps_pkg::PROD_W-1:0]     prod_up;
   logic [lps_pkg::WIDE_W-1:0]     wide;
   logic [lps_pkg::COUNT_W-1:0]    quot;
   logic                           last_addr;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign store_ok  = (count_ff < lps_pkg::COUNT_W'(lps_pkg::MAX_SAMPLES));
   assign wr_en     = accept && req_data.has_sample && store_ok;
   assign last_addr = (addr_ff == (count_ff - 1'b1));
   assign pidx      = step_ff[lps_pkg::STEP_W-1:1];

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lps_pkg::ST_IDLE: begin
            if (accept && req_data.set_end) begin
               if ((count_ff != '0) || wr_en) begin
                  state_in = lps_pkg::ST_RANK;
               end else begin
                  state_in = lps_pkg::ST_EMIT;
               end
            end
         end
         lps_pkg::ST_RANK: begin
            if (step_ff == lps_pkg::STEP_W'(2 * lps_pkg::NUM_POINTS - 1)) begin
               state_in = lps_pkg::ST_SCAN;
            end
         end
         lps_pkg::ST_SCAN: begin
            if (last_addr) begin
               state_in = lps_pkg::ST_DRAIN;
            end
         end
         lps_pkg::ST_DRAIN: begin
            state_in = lps_pkg::ST_UPDATE;
         end
         lps_pkg::ST_UPDATE: begin
            if (bit_ff == '0) begin
               state_in = lps_pkg::ST_WAIT_DIV;
            end else begin
               state_in = lps_pkg::ST_SCAN;
            end
         end
         lps_pkg::ST_WAIT_DIV: begin
            if (div_done) begin
               state_in = lps_pkg::ST_EMIT;
            end
         end
         lps_pkg::ST_EMIT: begin
            state_in = lps_pkg::ST_IDLE;
         end
         default: begin
            state_in = lps_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Outputs of the sequencer
   // ------------------------------------------------------------------
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      rd_en     = 1'b0;
      div_start = 1'b0;
      scan_ctrl = '{clear: 1'b0, rd_valid: rd_valid_ff, pass_end: 1'b0, bit_idx: bit_ff};
      unique case (state_ff)
         lps_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         lps_pkg::ST_RANK: begin
            scan_ctrl.clear = 1'b1;
            div_start       = (step_ff == '0);
         end
         lps_pkg::ST_SCAN: begin
            rd_en = 1'b1;
         end
         lps_pkg::ST_DRAIN: begin
         end
         lps_pkg::ST_UPDATE: begin
            scan_ctrl.pass_end = 1'b1;
         end
         lps_pkg::ST_WAIT_DIV: begin
         end
         lps_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Rank from point: ceil(p * n / 10000), clamped to at least 1.
   // Even steps form p * n, odd steps divide by the full scale.
   // ------------------------------------------------------------------
   always_comb begin
      point_cl = points_ff[pidx];
      if (point_cl > lps_pkg::POINT_W'(lps_pkg::FULL_SCALE)) begin
         point_cl = lps_pkg::POINT_W'(lps_pkg::FULL_SCALE);
      end
      prod_up = prod_ff + lps_pkg::PROD_W'(lps_pkg::FULL_SCALE - 1);
      wide    = lps_pkg::WIDE_W'(prod_up) * lps_pkg::WIDE_W'(lps_pkg::RECIP);
      quot    = wide[lps_pkg::RECIP_SHIFT +: lps_pkg::COUNT_W];
   end

   // ------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------
   always_comb begin
      points_in = points_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      drop_in   = drop_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      step_in   = step_ff;
      prod_in   = prod_ff;
      rank_in   = rank_ff;
      addr_in   = addr_ff;
      bit_in    = bit_ff;

      // hold config writes in range, drop the rest
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lps_pkg::CSR_POINT_A: points_in[0] = csr_wdata;
            lps_pkg::CSR_POINT_B: points_in[1] = csr_wdata;
            lps_pkg::CSR_POINT_C: points_in[2] = csr_wdata;
            lps_pkg::CSR_POINT_D: points_in[3] = csr_wdata;
            lps_pkg::CSR_POINT_E: points_in[4] = csr_wdata;
            default: begin
            end
         endcase
      end

      // take in a sample, or flag it dropped when the store is full
      if (accept && req_data.has_sample) begin
         if (store_ok) begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + lps_pkg::SUM_W'(req_data.sample_value);
            if ((count_ff == '0) || (req_data.sample_value < min_ff)) begin
               min_in = req_data.sample_value;
            end
            if ((count_ff == '0) || (req_data.sample_value > max_ff)) begin
               max_in = req_data.sample_value;
            end
         end else begin
            drop_in = 1'b1;
         end
      end

      if (accept && req_data.set_end) begin
         step_in = '0;
      end

      if (state_ff == lps_pkg::ST_RANK) begin
         step_in = step_ff + 1'b1;
         if (!step_ff[0]) begin
            prod_in = lps_pkg::PROD_W'(point_cl) * lps_pkg::PROD_W'(count_ff);
         end else begin
            rank_in[pidx] = (quot == '0) ? lps_pkg::COUNT_W'(1) : quot;
         end
         addr_in = '0;
         bit_in  = lps_pkg::BIT_IDX_W'(lps_pkg::SAMPLE_W - 1);
      end

      // advance through the store, one read per cycle
      if (state_ff == lps_pkg::ST_SCAN) begin
         addr_in = addr_ff + 1'b1;
      end

      if (state_ff == lps_pkg::ST_UPDATE) begin
         addr_in = '0;
         bit_in  = bit_ff - 1'b1;
      end

      // close the set
      if (state_ff == lps_pkg::ST_EMIT) begin
         count_in = '0;
         sum_in   = '0;
         drop_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lps_pkg::ST_IDLE;
         points_ff   <= lps_pkg::POINT_RESET;
         count_ff    <= '0;
         sum_ff      <= '0;
         drop_ff     <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         points_ff   <= points_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         drop_ff     <= drop_in;
         rd_valid_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      min_ff  <= min_in;
      max_ff  <= max_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      rank_ff <= rank_in;
      addr_ff <= addr_in;
      bit_ff  <= bit_in;
   end

   // ------------------------------------------------------------------
   // Units
   // ------------------------------------------------------------------
   lps_sample_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[lps_pkg::ADDR_W-1:0]),
      .wr_data (req_data.sample_value),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[lps_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   lps_mean_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (mean)
   );

   lps_rank_select u_sel (
      .clock   (clock),
      .ctrl    (scan_ctrl),
      .rd_data (rd_data),
      .ranks   (rank_ff),
      .values  (pct)
   );

   // ------------------------------------------------------------------
   // Result: all zeros for an empty set
   // ------------------------------------------------------------------
   always_comb begin
      rsp_data = '0;
      if (rsp_valid && (count_ff != '0)) begin
         rsp_data.sample_count = count_ff;
         rsp_data.min_value    = min_ff;
         rsp_data.max_value    = max_ff;
         rsp_data.mean_q8      = mean;
         rsp_data.pct_a_value  = pct[0];
         rsp_data.pct_b_value  = pct[1];
         rsp_data.pct_c_value  = pct[2];
         rsp_data.pct_d_value  = pct[3];
         rsp_data.pct_e_value  = pct[4];
         rsp_data.overflowed   = drop_ff;
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `LPS_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid && !busy)
   `LPS_ASSERT_NEXT(a_close_busy, clock, reset, accept && req_data.set_end, busy)
   `LPS_ASSERT_NOW(a_read_in_set, clock, reset, rd_en, addr_ff < count_ff)
   `LPS_ASSERT_NOW(a_emit_div_done, clock, reset, rsp_valid && (count_ff != '0), div_done)

endmodule

// File: rtl/core/lps_sample_mem.sv
// Sample store: one write port, one registered read port.
// Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_sample_mem (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [lps_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [lps_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [lps_pkg::ADDR_W-1:0]  rd_addr,
   output logic [lps_pkg::SAMPLE_W-1:0] rd_data
);

   logic [lps_pkg::SAMPLE_W-1:0] mem [lps_pkg::MAX_SAMPLES];
   logic [lps_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lps_mean_div.sv
// Restoring divider for the mean: (sum * 256) / count, one bit per cycle.
// Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_mean_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lps_pkg::SUM_W-1:0]    sum,
   input  logic [lps_pkg::COUNT_W-1:0]  divisor,
   output logic                         done,
   output logic [lps_pkg::MEAN_W-1:0]   quotient
);

   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [lps_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [lps_pkg::COUNT_W-1:0]    div_ff, div_in;
   logic [lps_pkg::COUNT_W-1:0]    rem_ff, rem_in;
   logic [lps_pkg::DIV_W-1:0]      quo_ff, quo_in;
   logic [lps_pkg::COUNT_W:0]      rem_sh;
   logic [lps_pkg::COUNT_W:0]      rem_sub;

   always_comb begin
      run_in  = run_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      rem_sh  = {rem_ff, quo_ff[lps_pkg::DIV_W-1]};
      rem_sub = rem_sh - {1'b0, div_ff};
      if (start) begin
         run_in  = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = {sum, {lps_pkg::FRAC_W{1'b0}}};
      end else if (run_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = rem_sub[lps_pkg::COUNT_W-1:0];
            quo_in = {quo_ff[lps_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[lps_pkg::COUNT_W-1:0];
            quo_in = {quo_ff[lps_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lps_pkg::DIV_CNT_W'(lps_pkg::DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[lps_pkg::MEAN_W-1:0];

endmodule

// File: rtl/core/lps_rank_select.sv
// Five selection lanes: bitwise search for the k-th smallest sample,
// one memory pass per result bit. Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_rank_select (
   input  logic                          clock,
   input  lps_pkg::scan_ctrl_type        ctrl,
   input  logic [lps_pkg::SAMPLE_W-1:0]  rd_data,
   input  lps_pkg::rank_vec_type         ranks,
   output lps_pkg::value_vec_type        values
);

   lps_pkg::value_vec_type       ans_ff, ans_in;
   lps_pkg::rank_vec_type        cnt_ff, cnt_in;
   logic [lps_pkg::SAMPLE_W-1:0] below_mask;
   logic [lps_pkg::SAMPLE_W-1:0] bit_mask;
   logic [lps_pkg::SAMPLE_W-1:0] cand;

   always_comb begin
      bit_mask   = lps_pkg::SAMPLE_W'(1) << ctrl.bit_idx;
      below_mask = bit_mask - lps_pkg::SAMPLE_W'(1);
      ans_in     = ans_ff;
      cnt_in     = cnt_ff;
      cand       = '0;
      for (int i = 0; i < lps_pkg::NUM_POINTS; i++) begin
         cand = ans_ff[i] | below_mask;
         if (ctrl.clear) begin
            ans_in[i] = '0;
            cnt_in[i] = '0;
         end else if (ctrl.pass_end) begin
            // too few samples at or below the candidate: the bit is one
            if (cnt_ff[i] < ranks[i]) begin
               ans_in[i] = ans_ff[i] | bit_mask;
            end
            cnt_in[i] = '0;
         end else if (ctrl.rd_valid && (rd_data <= cand)) begin
            cnt_in[i] = cnt_ff[i] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ans_ff <= ans_in;
      cnt_ff <= cnt_in;
   end

   assign values = ans_ff;

endmodule
